>>> sv/assert_macros.svh
// Assertion helpers for the region planner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RPL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("region planner check failed");
// next-cycle implication
`define RPL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("region planner check failed");
`else
`define RPL_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define RPL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> sv/rpl_pkg.sv
`default_nettype none
package rpl_pkg;

	localparam int COORD_BITS      = 16;
	localparam int SCALE_FRAC_BITS = 16;

	localparam logic [15:0] DIM_MAX      = 16'((1 << COORD_BITS) - 1);
	localparam logic [15:0] POS_MAX      = 16'((1 << (COORD_BITS - 1)) - 1);
	localparam logic [31:0] ONE_Q        = 32'(1) << SCALE_FRAC_BITS;
	localparam logic [48:0] HALF_Q       = 49'(1) << (SCALE_FRAC_BITS - 1);
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
	localparam logic [31:0] SCALE_MAX    = 32'hffff_ffff;

	// register indexes
	localparam logic [2:0] REG_PAD_ENABLE    = 3'd0;
	localparam logic [2:0] REG_PAD_X         = 3'd1;
	localparam logic [2:0] REG_PAD_Y         = 3'd2;
	localparam logic [2:0] REG_FILL_RGB      = 3'd3;
	localparam logic [2:0] REG_RESIZE_MODE   = 3'd4;
	localparam logic [2:0] REG_CROP_MODE     = 3'd5;
	localparam logic [2:0] REG_TARGET_WIDTH  = 3'd6;
	localparam logic [2:0] REG_TARGET_HEIGHT = 3'd7;

	// resize modes
	localparam logic [1:0] RS_NONE    = 2'd0;
	localparam logic [1:0] RS_STRETCH = 2'd1;
	localparam logic [1:0] RS_KEEP    = 2'd2;

	// crop modes
	localparam logic [2:0] CR_NONE         = 3'd0;
	localparam logic [2:0] CR_CENTRE       = 3'd1;
	localparam logic [2:0] CR_TOP_LEFT     = 3'd2;
	localparam logic [2:0] CR_TOP_RIGHT    = 3'd3;
	localparam logic [2:0] CR_BOTTOM_LEFT  = 3'd4;
	localparam logic [2:0] CR_BOTTOM_RIGHT = 3'd5;
	localparam logic [2:0] CR_SQUARE       = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PAD_ERR = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	// per-item context carried down the pipeline
	typedef struct packed {
		logic        err;
		logic        sat;
		logic        rz;
		logic        uns;
		logic        do_pad;
		logic [3:0]  usat;
		logic [15:0] img_w;
		logic [15:0] img_h;
		logic [15:0] src_x;
		logic [15:0] src_y;
		logic [15:0] src_w;
		logic [15:0] src_h;
		logic [15:0] rw;
		logic [15:0] rh;
		logic [15:0] uw;
		logic [15:0] uh;
		logic [15:0] dw;
		logic [15:0] dh;
		logic [31:0] scx;
		logic [31:0] scy;
	} ctx_t;

	// scale divider lane: (usable << F) / region size
	typedef struct packed {
		logic [15:0] rem;
		logic [31:0] quo;
		logic [15:0] dvd;
	} sd_lane_t;

	// unscale divider lane: (v << F) / scale, v < scale
	typedef struct packed {
		logic [31:0] rem;
		logic [15:0] quo;
	} ud_lane_t;

	// result payload
	typedef struct packed {
		logic [15:0] src_x;
		logic [15:0] src_y;
		logic [15:0] src_w;
		logic [15:0] src_h;
		logic [15:0] dst_x;
		logic [15:0] dst_y;
		logic [15:0] dst_w;
		logic [15:0] dst_h;
		logic [31:0] bg;
		logic [31:0] scx;
		logic [31:0] scy;
		logic [1:0]  status;
	} res_t;

	// one restoring step of the scale divider
	function automatic sd_lane_t sd_step(input sd_lane_t a, input logic [15:0] d);
		sd_lane_t r;
		logic [16:0] t;
		t = {a.rem, a.dvd[15]};
		r.dvd = {a.dvd[14:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem = 16'(t - {1'b0, d});
			r.quo = {a.quo[30:0], 1'b1};
		end else begin
			r.rem = t[15:0];
			r.quo = {a.quo[30:0], 1'b0};
		end
		return r;
	endfunction

	// one restoring step of the unscale divider
	function automatic ud_lane_t ud_step(input ud_lane_t a, input logic [31:0] s);
		ud_lane_t r;
		logic [32:0] t;
		t = {a.rem, 1'b0};
		if (t >= {1'b0, s}) begin
			r.rem = 32'(t - {1'b0, s});
			r.quo = {a.quo[14:0], 1'b1};
		end else begin
			r.rem = t[31:0];
			r.quo = {a.quo[14:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/rpl_if.sv
`default_nettype none
// request channel: one frame's source geometry
interface rpl_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [14:0] roi_x;
	logic [14:0] roi_y;
	logic [15:0] roi_width;
	logic [15:0] roi_height;
	logic        already_padded;

	modport source(output valid, image_width, image_height, roi_x, roi_y, roi_width,
		roi_height, already_padded, input ready);
	modport sink(input valid, image_width, image_height, roi_x, roi_y, roi_width,
		roi_height, already_padded, output ready);
endinterface

// response channel: planned rectangles, scales and status
interface rpl_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] src_x_out;
	logic signed [15:0] src_y_out;
	logic [15:0]        src_w_out;
	logic [15:0]        src_h_out;
	logic signed [15:0] dst_x_out;
	logic signed [15:0] dst_y_out;
	logic [15:0]        dst_w_out;
	logic [15:0]        dst_h_out;
	logic [31:0]        background;
	logic [31:0]        scale_x_q16;
	logic [31:0]        scale_y_q16;
	logic [1:0]         status;

	modport source(output valid, src_x_out, src_y_out, src_w_out, src_h_out, dst_x_out,
		dst_y_out, dst_w_out, dst_h_out, background, scale_x_q16, scale_y_q16, status,
		input ready);
	modport sink(input valid, src_x_out, src_y_out, src_w_out, src_h_out, dst_x_out,
		dst_y_out, dst_w_out, dst_h_out, background, scale_x_q16, scale_y_q16, status,
		output ready);
endinterface
`default_nettype wire

>>> sv/preproc_region_planner_unit.sv
// Depth: 38 register stages, from the input register through the result register.
// Throughput: one transaction per cycle unless the response side stalls; the two 16-stage
// restoring dividers (scale, then crop unscale) are fully pipelined and set the depth.
// A stall on the response side freezes the whole pipeline; nothing is dropped.
// Reset (arst_n low, asynchronous) clears all valid bits and all configuration
// registers to zero; pipeline data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module preproc_region_planner_unit (
	input  wire         clk,
	input  wire         arst_n,
	rpl_req_if.sink     req,
	rpl_rsp_if.source   rsp,
	input  wire         wr_en,
	input  wire  [2:0]  wr_idx,
	input  wire  [23:0] wr_data
);

	// configuration registers
	logic        pad_enable_q;
	logic [15:0] pad_x_q;
	logic [15:0] pad_y_q;
	logic [23:0] fill_rgb_q;
	logic [1:0]  resize_mode_q;
	logic [2:0]  crop_mode_q;
	logic [15:0] target_width_q;
	logic [15:0] target_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_enable_q    <= 1'b0;
			pad_x_q         <= '0;
			pad_y_q         <= '0;
			fill_rgb_q      <= '0;
			resize_mode_q   <= '0;
			crop_mode_q     <= '0;
			target_width_q  <= '0;
			target_height_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				rpl_pkg::REG_PAD_ENABLE:    pad_enable_q    <= wr_data[0];
				rpl_pkg::REG_PAD_X:         pad_x_q         <= wr_data[15:0];
				rpl_pkg::REG_PAD_Y:         pad_y_q         <= wr_data[15:0];
				rpl_pkg::REG_FILL_RGB:      fill_rgb_q      <= wr_data;
				rpl_pkg::REG_RESIZE_MODE:   resize_mode_q   <= wr_data[1:0];
				rpl_pkg::REG_CROP_MODE:     crop_mode_q     <= wr_data[2:0];
				rpl_pkg::REG_TARGET_WIDTH:  target_width_q  <= wr_data[15:0];
				rpl_pkg::REG_TARGET_HEIGHT: target_height_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// user changes configuration only while idle (unenforced); read directly at every stage
	logic crop_on;
	assign crop_on = (crop_mode_q != rpl_pkg::CR_NONE) && (crop_mode_q <= rpl_pkg::CR_SQUARE);

	// pipeline control: whole pipe advances unless the output holds a stalled transaction
	logic [38:1] stage_vld_q;
	logic        adv;
	assign adv       = !stage_vld_q[38] || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[37:1], req.valid};
		end
	end

	// stage 1: padding, usable area, resize decision
	rpl_pkg::ctx_t    sd_ctx_s [0:16];
	rpl_pkg::sd_lane_t sdx_s   [0:16];
	rpl_pkg::sd_lane_t sdy_s   [0:16];

	logic          in_pad;
	logic [15:0]   in_px, in_py, in_uw, in_uh;
	logic          in_err;
	rpl_pkg::ctx_t in_ctx;

	always_comb begin
		in_pad = pad_enable_q && !req.already_padded;
		in_px  = in_pad ? pad_x_q : 16'd0;
		in_py  = in_pad ? pad_y_q : 16'd0;
		in_err = ({in_px, 1'b0} > {1'b0, target_width_q}) ||
			({in_py, 1'b0} > {1'b0, target_height_q});
		in_uw  = target_width_q - {in_px[14:0], 1'b0};
		in_uh  = target_height_q - {in_py[14:0], 1'b0};

		in_ctx        = '0;
		in_ctx.err    = in_err;
		in_ctx.do_pad = in_pad;
		in_ctx.img_w  = req.image_width;
		in_ctx.img_h  = req.image_height;
		in_ctx.src_x  = {1'b0, req.roi_x};
		in_ctx.src_y  = {1'b0, req.roi_y};
		in_ctx.src_w  = req.roi_width;
		in_ctx.src_h  = req.roi_height;
		in_ctx.rw     = req.roi_width;
		in_ctx.rh     = req.roi_height;
		in_ctx.uw     = in_uw;
		in_ctx.uh     = in_uh;
		in_ctx.dw     = req.roi_width;
		in_ctx.dh     = req.roi_height;
		in_ctx.scx    = rpl_pkg::ONE_Q;
		in_ctx.scy    = rpl_pkg::ONE_Q;
		in_ctx.rz     = (resize_mode_q != rpl_pkg::RS_NONE) &&
			((req.roi_width != in_uw) || (req.roi_height != in_uh));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_ctx_s[0] <= in_ctx;
			sdx_s[0]    <= '{rem: 16'd0, quo: 32'd0, dvd: in_uw};
			sdy_s[0]    <= '{rem: 16'd0, quo: 32'd0, dvd: in_uh};
		end
	end

	// stages 2..17: scale divider, two quotient bits per stage
	for (genvar k = 1; k <= 16; k++) begin : g_sdiv
		always_ff @(posedge clk) begin
			if (adv) begin
				sd_ctx_s[k] <= sd_ctx_s[k-1];
				sdx_s[k]    <= rpl_pkg::sd_step(rpl_pkg::sd_step(sdx_s[k-1],
					sd_ctx_s[k-1].rw), sd_ctx_s[k-1].rw);
				sdy_s[k]    <= rpl_pkg::sd_step(rpl_pkg::sd_step(sdy_s[k-1],
					sd_ctx_s[k-1].rh), sd_ctx_s[k-1].rh);
			end
		end
	end

	// stage 18: zero-size guard, aspect minimum, 9/8 overscale, saturation
	rpl_pkg::ctx_t ctx_s18, sel_ctx;
	logic [31:0]   qx, qy;
	logic [32:0]   ox9, oy9;

	always_comb begin
		sel_ctx = sd_ctx_s[16];
		qx = (sel_ctx.rw == 16'd0) ? rpl_pkg::ONE_Q : sdx_s[16].quo;
		qy = (sel_ctx.rh == 16'd0) ? rpl_pkg::ONE_Q : sdy_s[16].quo;
		if (resize_mode_q == rpl_pkg::RS_KEEP) begin
			if (qy < qx) qx = qy;
			else qy = qx;
		end
		ox9 = {1'b0, qx} + {4'b0, qx[31:3]};
		oy9 = {1'b0, qy} + {4'b0, qy[31:3]};
		if (sel_ctx.rz) begin
			if (crop_on) begin
				sel_ctx.scx = ox9[32] ? rpl_pkg::SCALE_MAX : ox9[31:0];
				sel_ctx.scy = oy9[32] ? rpl_pkg::SCALE_MAX : oy9[31:0];
				sel_ctx.sat = sel_ctx.sat | ox9[32] | oy9[32];
			end else begin
				sel_ctx.scx = qx;
				sel_ctx.scy = qy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) ctx_s18 <= sel_ctx;
	end

	// stage 19: size times scale
	rpl_pkg::ctx_t ctx_s19;
	logic [47:0]   prod_x_s19, prod_y_s19;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s19    <= ctx_s18;
			prod_x_s19 <= ctx_s18.rw * ctx_s18.scx;
			prod_y_s19 <= ctx_s18.rh * ctx_s18.scy;
		end
	end

	// stage 20: round half up and saturate scaled size
	rpl_pkg::ctx_t ctx_s20, rnd_ctx;
	logic [48:0]   rnd_x, rnd_y;
	logic [32:0]   shx, shy;

	always_comb begin
		rnd_ctx = ctx_s19;
		rnd_x   = {1'b0, prod_x_s19} + rpl_pkg::HALF_Q;
		rnd_y   = {1'b0, prod_y_s19} + rpl_pkg::HALF_Q;
		shx     = 33'(rnd_x >> rpl_pkg::SCALE_FRAC_BITS);
		shy     = 33'(rnd_y >> rpl_pkg::SCALE_FRAC_BITS);
		if (rnd_ctx.rz) begin
			rnd_ctx.dw  = (|shx[32:16]) ? rpl_pkg::DIM_MAX : shx[15:0];
			rnd_ctx.dh  = (|shy[32:16]) ? rpl_pkg::DIM_MAX : shy[15:0];
			rnd_ctx.sat = rnd_ctx.sat | (|shx[32:16]) | (|shy[32:16]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) ctx_s20 <= rnd_ctx;
	end

	// stage 21: crop placement and unscale divider set-up
	rpl_pkg::ctx_t     ud_ctx_s [0:16];
	rpl_pkg::ud_lane_t ud_s     [0:16][0:3];

	rpl_pkg::ctx_t crp_ctx;
	logic          crp;
	logic [15:0]   bx, by, cw, ch, side;
	logic [15:0]   uv [0:3];
	logic [31:0]   us [0:3];

	always_comb begin
		crp_ctx = ctx_s20;
		crp  = crop_on && ((crp_ctx.dw != crp_ctx.uw) || (crp_ctx.dh != crp_ctx.uh));
		bx   = (crp_ctx.dw > crp_ctx.uw) ? crp_ctx.dw - crp_ctx.uw : 16'd0;
		by   = (crp_ctx.dh > crp_ctx.uh) ? crp_ctx.dh - crp_ctx.uh : 16'd0;
		cw   = crp_ctx.dw - bx;
		ch   = crp_ctx.dh - by;
		side = (crp_ctx.img_w < crp_ctx.img_h) ? crp_ctx.img_w : crp_ctx.img_h;
		case (crop_mode_q)
			rpl_pkg::CR_CENTRE: begin
				bx = {1'b0, bx[15:1]};
				by = {1'b0, by[15:1]};
			end
			rpl_pkg::CR_TOP_LEFT: begin
				bx = 16'd0;
				by = 16'd0;
			end
			rpl_pkg::CR_TOP_RIGHT:    by = 16'd0;
			rpl_pkg::CR_BOTTOM_LEFT:  bx = 16'd0;
			rpl_pkg::CR_BOTTOM_RIGHT: ;
			default: ;
		endcase
		if (crp) begin
			if (crop_mode_q == rpl_pkg::CR_SQUARE) begin
				crp_ctx.src_x = 16'((crp_ctx.img_w - side) >> 1);
				crp_ctx.src_y = 16'((crp_ctx.img_h - side) >> 1);
				crp_ctx.src_w = side;
				crp_ctx.src_h = side;
				crp_ctx.dw    = crp_ctx.uw;
				crp_ctx.dh    = crp_ctx.uh;
			end else begin
				crp_ctx.dw  = cw;
				crp_ctx.dh  = ch;
				crp_ctx.uns = 1'b1;
			end
		end
		// lanes: left border, top border, width, height
		uv[0] = bx;
		uv[1] = by;
		uv[2] = cw;
		uv[3] = ch;
		us[0] = crp_ctx.scx;
		us[1] = crp_ctx.scy;
		us[2] = crp_ctx.scx;
		us[3] = crp_ctx.scy;
		for (int i = 0; i < 4; i++) begin
			crp_ctx.usat[i] = (us[i] == 32'd0) || ({16'd0, uv[i]} >= us[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ud_ctx_s[0] <= crp_ctx;
			for (int i = 0; i < 4; i++) begin
				ud_s[0][i] <= '{rem: {16'd0, uv[i]}, quo: 16'd0};
			end
		end
	end

	// stages 22..37: unscale dividers, one quotient bit per stage, four lanes
	for (genvar k = 1; k <= 16; k++) begin : g_udiv
		always_ff @(posedge clk) begin
			if (adv) begin
				ud_ctx_s[k] <= ud_ctx_s[k-1];
				ud_s[k][0]  <= rpl_pkg::ud_step(ud_s[k-1][0], ud_ctx_s[k-1].scx);
				ud_s[k][1]  <= rpl_pkg::ud_step(ud_s[k-1][1], ud_ctx_s[k-1].scy);
				ud_s[k][2]  <= rpl_pkg::ud_step(ud_s[k-1][2], ud_ctx_s[k-1].scx);
				ud_s[k][3]  <= rpl_pkg::ud_step(ud_s[k-1][3], ud_ctx_s[k-1].scy);
			end
		end
	end

	// stage 38: source offset, centring, result assembly
	rpl_pkg::ctx_t fin_ctx;
	rpl_pkg::res_t fin_res, res_s38;
	logic [15:0]   ux [0:3];
	logic [16:0]   nx, ny;
	logic [16:0]   dxs, dys, dxa, dya;

	always_comb begin
		fin_ctx = ud_ctx_s[16];
		for (int i = 0; i < 4; i++) begin
			ux[i] = fin_ctx.usat[i] ? rpl_pkg::DIM_MAX : ud_s[16][i].quo;
		end
		nx = {1'b0, fin_ctx.src_x} + {1'b0, ux[0]};
		ny = {1'b0, fin_ctx.src_y} + {1'b0, ux[1]};
		if (fin_ctx.uns) begin
			fin_ctx.src_w = ux[2];
			fin_ctx.src_h = ux[3];
			fin_ctx.src_x = (nx > {1'b0, rpl_pkg::POS_MAX}) ? rpl_pkg::POS_MAX : nx[15:0];
			fin_ctx.src_y = (ny > {1'b0, rpl_pkg::POS_MAX}) ? rpl_pkg::POS_MAX : ny[15:0];
			fin_ctx.sat   = fin_ctx.sat | (|fin_ctx.usat) |
				(nx > {1'b0, rpl_pkg::POS_MAX}) | (ny > {1'b0, rpl_pkg::POS_MAX});
		end
		// (target - size) / 2, truncated toward zero
		dxs = {1'b0, target_width_q} - {1'b0, fin_ctx.dw};
		dys = {1'b0, target_height_q} - {1'b0, fin_ctx.dh};
		dxa = dxs + {16'd0, dxs[16]};
		dya = dys + {16'd0, dys[16]};

		fin_res = '0;
		if (fin_ctx.err) begin
			fin_res.status = rpl_pkg::ST_PAD_ERR;
		end else begin
			fin_res.src_x  = fin_ctx.src_x;
			fin_res.src_y  = fin_ctx.src_y;
			fin_res.src_w  = fin_ctx.src_w;
			fin_res.src_h  = fin_ctx.src_h;
			fin_res.dst_x  = dxa[16:1];
			fin_res.dst_y  = dya[16:1];
			fin_res.dst_w  = fin_ctx.dw;
			fin_res.dst_h  = fin_ctx.dh;
			fin_res.bg     = {rpl_pkg::ALPHA_OPAQUE, fin_ctx.do_pad ? fill_rgb_q : 24'd0};
			fin_res.scx    = fin_ctx.scx;
			fin_res.scy    = fin_ctx.scy;
			fin_res.status = fin_ctx.sat ? rpl_pkg::ST_SAT : rpl_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s38 <= fin_res;
	end

	// response channel
	assign rsp.valid       = stage_vld_q[38];
	assign rsp.src_x_out   = res_s38.src_x;
	assign rsp.src_y_out   = res_s38.src_y;
	assign rsp.src_w_out   = res_s38.src_w;
	assign rsp.src_h_out   = res_s38.src_h;
	assign rsp.dst_x_out   = res_s38.dst_x;
	assign rsp.dst_y_out   = res_s38.dst_y;
	assign rsp.dst_w_out   = res_s38.dst_w;
	assign rsp.dst_h_out   = res_s38.dst_h;
	assign rsp.background  = res_s38.bg;
	assign rsp.scale_x_q16 = res_s38.scx;
	assign rsp.scale_y_q16 = res_s38.scy;
	assign rsp.status      = res_s38.status;

	// checks
	`RPL_ASSERT_NOW(a_pad_err_zero, clk, arst_n, rsp.valid && (rsp.status == rpl_pkg::ST_PAD_ERR), (rsp.dst_w_out == 16'd0) && (rsp.scale_x_q16 == 32'd0) && (rsp.background == 32'd0))
	`RPL_ASSERT_NOW(a_alpha_opaque, clk, arst_n, rsp.valid && (rsp.status != rpl_pkg::ST_PAD_ERR), rsp.background[31:24] == rpl_pkg::ALPHA_OPAQUE)
	`RPL_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !adv, $stable(stage_vld_q))

endmodule
`default_nettype wire

>>> sim/preproc_region_planner_unit_tb.sv
`default_nettype none
module preproc_region_planner_unit_tb;

	localparam int HALF_PERIOD = 6;
	localparam int LATENCY     = 38;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_idx = '0;
	logic [23:0] wr_data = '0;

	rpl_req_if req ();
	rpl_rsp_if rsp ();

	preproc_region_planner_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// one frame's request geometry
	typedef struct packed {
		logic [15:0] img_w;
		logic [15:0] img_h;
		logic [14:0] rx;
		logic [14:0] ry;
		logic [15:0] rw;
		logic [15:0] rh;
		logic        padded;
	} frame_t;

	// shadow copy of the configuration
	logic        m_pad_en;
	logic [15:0] m_pad_x, m_pad_y, m_tw, m_th;
	logic [23:0] m_fill;
	logic [1:0]  m_resize;
	logic [2:0]  m_crop;

	rpl_pkg::res_t plan_q[$];
	int   errors = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_cfg = 0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;

	function automatic logic [15:0] sat_dim(input logic [63:0] v, inout logic sat);
		if (v > 64'(rpl_pkg::DIM_MAX)) begin
			sat = 1'b1;
			return rpl_pkg::DIM_MAX;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] unscale_dim(input logic [15:0] v, input logic [63:0] s,
			inout logic sat);
		if (s == 0) begin
			sat = 1'b1;
			return rpl_pkg::DIM_MAX;
		end
		return sat_dim((64'(v) << rpl_pkg::SCALE_FRAC_BITS) / s, sat);
	endfunction

	// planned rectangles and scales for one frame
	function automatic rpl_pkg::res_t plan_frame(input frame_t f);
		rpl_pkg::res_t r;
		logic        sat, do_pad, crop_on;
		logic [31:0] px, py, uw, uh, dw, dh, bx, by, cw, ch, side;
		logic [63:0] scx, scy, sx, sy, sw, sh, nx, ny;
		int          ox, oy;
		r = '0;
		sat = 1'b0;
		do_pad = m_pad_en && !f.padded;
		crop_on = (m_crop >= rpl_pkg::CR_CENTRE) && (m_crop <= rpl_pkg::CR_SQUARE);
		px = do_pad ? 32'(m_pad_x) : 0;
		py = do_pad ? 32'(m_pad_y) : 0;
		if (2 * px > 32'(m_tw) || 2 * py > 32'(m_th)) begin
			r.status = rpl_pkg::ST_PAD_ERR;
			return r;
		end
		uw = 32'(m_tw) - 2 * px;
		uh = 32'(m_th) - 2 * py;
		sx = f.rx; sy = f.ry; sw = f.rw; sh = f.rh;
		dw = f.rw; dh = f.rh;
		scx = 64'(rpl_pkg::ONE_Q); scy = 64'(rpl_pkg::ONE_Q);
		// resize step
		if (m_resize != rpl_pkg::RS_NONE && (32'(f.rw) != uw || 32'(f.rh) != uh)) begin
			if (f.rw != 0) scx = (64'(uw) << rpl_pkg::SCALE_FRAC_BITS) / f.rw;
			if (f.rh != 0) scy = (64'(uh) << rpl_pkg::SCALE_FRAC_BITS) / f.rh;
			if (m_resize == rpl_pkg::RS_KEEP) begin
				if (scy < scx) scx = scy; else scy = scx;
			end
			if (crop_on) begin
				scx = scx * 9 / 8;
				scy = scy * 9 / 8;
			end
			if (scx > 64'(rpl_pkg::SCALE_MAX)) begin scx = rpl_pkg::SCALE_MAX; sat = 1'b1; end
			if (scy > 64'(rpl_pkg::SCALE_MAX)) begin scy = rpl_pkg::SCALE_MAX; sat = 1'b1; end
			dw = sat_dim((64'(f.rw) * scx + 64'(rpl_pkg::HALF_Q)) >> rpl_pkg::SCALE_FRAC_BITS,
				sat);
			dh = sat_dim((64'(f.rh) * scy + 64'(rpl_pkg::HALF_Q)) >> rpl_pkg::SCALE_FRAC_BITS,
				sat);
		end
		// crop step
		if (crop_on && (dw != uw || dh != uh)) begin
			bx = dw > uw ? dw - uw : 0;
			by = dh > uh ? dh - uh : 0;
			cw = dw - bx; ch = dh - by;
			if (m_crop == rpl_pkg::CR_SQUARE) begin
				side = f.img_w < f.img_h ? f.img_w : f.img_h;
				sx = (32'(f.img_w) - side) / 2;
				sy = (32'(f.img_h) - side) / 2;
				sw = side; sh = side;
				dw = uw; dh = uh;
			end else begin
				case (m_crop)
					rpl_pkg::CR_CENTRE: begin bx = bx / 2; by = by / 2; end
					rpl_pkg::CR_TOP_LEFT: begin bx = 0; by = 0; end
					rpl_pkg::CR_TOP_RIGHT: by = 0;
					rpl_pkg::CR_BOTTOM_LEFT: bx = 0;
					default: ;
				endcase
				dw = cw; dh = ch;
				bx = unscale_dim(bx[15:0], scx, sat);
				by = unscale_dim(by[15:0], scy, sat);
				sw = unscale_dim(cw[15:0], scx, sat);
				sh = unscale_dim(ch[15:0], scy, sat);
				nx = sx + bx;
				ny = sy + by;
				if (nx > 64'(rpl_pkg::POS_MAX)) begin nx = rpl_pkg::POS_MAX; sat = 1'b1; end
				if (ny > 64'(rpl_pkg::POS_MAX)) begin ny = rpl_pkg::POS_MAX; sat = 1'b1; end
				sx = nx; sy = ny;
			end
		end
		// centre the output in the target
		ox = (int'(m_tw) - int'(dw)) / 2;
		oy = (int'(m_th) - int'(dh)) / 2;
		r.src_x = sx[15:0]; r.src_y = sy[15:0];
		r.src_w = sw[15:0]; r.src_h = sh[15:0];
		r.dst_x = ox[15:0]; r.dst_y = oy[15:0];
		r.dst_w = dw[15:0]; r.dst_h = dh[15:0];
		r.bg = {rpl_pkg::ALPHA_OPAQUE, do_pad ? m_fill : 24'h0};
		r.scx = scx[31:0]; r.scy = scy[31:0];
		r.status = sat ? rpl_pkg::ST_SAT : rpl_pkg::ST_OK;
		return r;
	endfunction

	// register write, block idle
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(negedge clk);
		wr_en <= 1'b1; wr_idx <= idx; wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			rpl_pkg::REG_PAD_ENABLE: m_pad_en = val[0];
			rpl_pkg::REG_PAD_X: m_pad_x = val[15:0];
			rpl_pkg::REG_PAD_Y: m_pad_y = val[15:0];
			rpl_pkg::REG_FILL_RGB: m_fill = val;
			rpl_pkg::REG_RESIZE_MODE: m_resize = val[1:0];
			rpl_pkg::REG_CROP_MODE: m_crop = val[2:0];
			rpl_pkg::REG_TARGET_WIDTH: m_tw = val[15:0];
			rpl_pkg::REG_TARGET_HEIGHT: m_th = val[15:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// stop sending and wait until every accepted transaction has been checked
	task automatic wait_drain();
		req.valid <= 1'b0;
		while (plan_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_config(input logic pe, input logic [15:0] px, input logic [15:0] py,
			input logic [23:0] fill, input logic [1:0] rs, input logic [2:0] cr,
			input logic [15:0] tw, input logic [15:0] th);
		wait_drain();
		write_reg(rpl_pkg::REG_PAD_ENABLE, 24'(pe));
		write_reg(rpl_pkg::REG_PAD_X, 24'(px));
		write_reg(rpl_pkg::REG_PAD_Y, 24'(py));
		write_reg(rpl_pkg::REG_FILL_RGB, fill);
		write_reg(rpl_pkg::REG_RESIZE_MODE, 24'(rs));
		write_reg(rpl_pkg::REG_CROP_MODE, 24'(cr));
		write_reg(rpl_pkg::REG_TARGET_WIDTH, 24'(tw));
		write_reg(rpl_pkg::REG_TARGET_HEIGHT, 24'(th));
	endtask

	// send one frame; prediction queued on acceptance, valid left high for back to back
	task automatic send_frame(input frame_t f);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.image_width <= f.img_w; req.image_height <= f.img_h;
		req.roi_x <= f.rx; req.roi_y <= f.ry;
		req.roi_width <= f.rw; req.roi_height <= f.rh;
		req.already_padded <= f.padded;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		plan_q.push_back(plan_frame(f));
		n_sent++;
		@(negedge clk);
	endtask

	function automatic frame_t rand_frame(input int mag);
		frame_t f;
		f.img_w = 16'($urandom_range(mag));
		f.img_h = 16'($urandom_range(mag));
		f.rx = 15'($urandom_range(mag > 32767 ? 32767 : mag));
		f.ry = 15'($urandom_range(mag > 32767 ? 32767 : mag));
		f.rw = 16'($urandom_range(mag));
		f.rh = 16'($urandom_range(mag));
		f.padded = 1'($urandom);
		return f;
	endfunction

	// receiver: random stalls, field-by-field check
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		rpl_pkg::res_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (plan_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
			end else begin
				e = plan_q.pop_front();
				n_checked++;
				if (rsp.src_x_out !== e.src_x) begin
					$error("src_x_out exp %0h got %0h", e.src_x, rsp.src_x_out); errors++; end
				if (rsp.src_y_out !== e.src_y) begin
					$error("src_y_out exp %0h got %0h", e.src_y, rsp.src_y_out); errors++; end
				if (rsp.src_w_out !== e.src_w) begin
					$error("src_w_out exp %0h got %0h", e.src_w, rsp.src_w_out); errors++; end
				if (rsp.src_h_out !== e.src_h) begin
					$error("src_h_out exp %0h got %0h", e.src_h, rsp.src_h_out); errors++; end
				if (rsp.dst_x_out !== e.dst_x) begin
					$error("dst_x_out exp %0h got %0h", e.dst_x, rsp.dst_x_out); errors++; end
				if (rsp.dst_y_out !== e.dst_y) begin
					$error("dst_y_out exp %0h got %0h", e.dst_y, rsp.dst_y_out); errors++; end
				if (rsp.dst_w_out !== e.dst_w) begin
					$error("dst_w_out exp %0h got %0h", e.dst_w, rsp.dst_w_out); errors++; end
				if (rsp.dst_h_out !== e.dst_h) begin
					$error("dst_h_out exp %0h got %0h", e.dst_h, rsp.dst_h_out); errors++; end
				if (rsp.background !== e.bg) begin
					$error("background exp %0h got %0h", e.bg, rsp.background); errors++; end
				if (rsp.scale_x_q16 !== e.scx) begin
					$error("scale_x_q16 exp %0h got %0h", e.scx, rsp.scale_x_q16); errors++; end
				if (rsp.scale_y_q16 !== e.scy) begin
					$error("scale_y_q16 exp %0h got %0h", e.scy, rsp.scale_y_q16); errors++; end
				if (rsp.status !== e.status) begin
					$error("status exp %0h got %0h", e.status, rsp.status); errors++; end
			end
		end
	end

	// directed: extremes, every mode, special cases
	task automatic test_directed();
		frame_t f;
		// reset config: zero target, no padding
		f = '{16'd640, 16'd480, 15'd0, 15'd0, 16'd640, 16'd480, 1'b0};
		send_frame(f);
		// padding too large, then padding suppressed by already_padded
		set_config(1'b1, 16'd200, 16'd10, 24'hA5C3F0, rpl_pkg::RS_STRETCH, rpl_pkg::CR_NONE,
			16'd300, 16'd200);
		send_frame(f);
		f.padded = 1'b1;
		send_frame(f);
		// zero region size keeps unit scale
		f = '{16'd100, 16'd100, 15'd5, 15'd5, 16'd0, 16'd0, 1'b0};
		set_config(1'b1, 16'd10, 16'd10, 24'hFFFFFF, rpl_pkg::RS_STRETCH, rpl_pkg::CR_NONE,
			16'd320, 16'd240);
		send_frame(f);
		// each crop mode, resize mode cycling through all four codes, incl. modes beyond range
		for (int c = 0; c < 8; c++) begin
			set_config(1'b0, 16'd0, 16'd0, 24'h0, 2'(c % 4), 3'(c), 16'd300, 16'd200);
			f = '{16'd1920, 16'd1080, 15'd40, 15'd30, 16'd640, 16'd360, 1'(c & 1)};
			send_frame(f);
			f = '{16'hFFFF, 16'd7, 15'h7FFF, 15'h7FFF, 16'd1, 16'hFFFF, 1'b0};
			send_frame(f);
		end
		// saturating scale and dimensions, full-range fields, resize mode out of range
		set_config(1'b1, 16'd0, 16'd0, 24'h123456, 2'd3, rpl_pkg::CR_CENTRE,
			16'hFFFF, 16'hFFFF);
		f = '{16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'd1, 16'd1, 1'b0};
		send_frame(f);
		f = '{16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1};
		send_frame(f);
		// zero target with crop gives zero scale for a nonzero region
		set_config(1'b0, 16'd0, 16'd0, 24'h0, rpl_pkg::RS_STRETCH, rpl_pkg::CR_BOTTOM_RIGHT,
			16'd0, 16'd0);
		f = '{16'd9, 16'd9, 15'd3, 15'd3, 16'd9, 16'd9, 1'b0};
		send_frame(f);
		f = '{16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0, 1'b0};
		send_frame(f);
	endtask

	// random phases: mostly sane configs, a few extremes
	task automatic test_random(input int n_items);
		int mag, tw, th;
		for (int i = 0; i < n_items; i++) begin
			if (i % 60 == 0) begin
				tw = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(2000);
				th = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(2000);
				set_config(1'($urandom), 16'($urandom_range($urandom_range(1) ? 40 : 65535)),
					16'($urandom_range($urandom_range(1) ? 40 : 65535)), 24'($urandom),
					2'($urandom), 3'($urandom), 16'(tw), 16'(th));
			end
			mag = ($urandom_range(9) == 0) ? 65535 : 4000;
			send_frame(rand_frame(mag));
		end
	endtask

	initial begin
		m_pad_en = 0; m_pad_x = 0; m_pad_y = 0; m_fill = 0;
		m_resize = 0; m_crop = 0; m_tw = 0; m_th = 0;
		req.valid = 1'b0; req.image_width = '0; req.image_height = '0;
		req.roi_x = '0; req.roi_y = '0; req.roi_width = '0; req.roi_height = '0;
		req.already_padded = 1'b0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		src_idle_pct = 18; snk_idle_pct = 75;
		test_directed();
		test_random(480);
		src_idle_pct = 75; snk_idle_pct = 18;
		test_random(480);
		src_idle_pct = 0; snk_idle_pct = 0;
		test_random(480);
		wait_drain();
		if (plan_q.size() != 0) begin
			$error("%0d expected results never arrived", plan_q.size());
			errors++;
		end
		$display("Sent %0d frames, checked %0d results, %0d register writes.",
			n_sent, n_checked, n_cfg);
		$display("Covered padding, resize and crop modes under mixed stalls; %0d errors.",
			errors);
		if (errors == 0) begin
			$display("** preproc_region_planner_unit: PASSED **");
		end else begin
			$display("** preproc_region_planner_unit: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 600000);
		$display("** preproc_region_planner_unit: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+sv
sv/rpl_pkg.sv
sv/rpl_if.sv
sv/preproc_region_planner_unit.sv
sim/preproc_region_planner_unit_tb.sv
